>>> rtl/core/salc_pkg.sv
// Shared types and codes for the set-associative LRU cache tag store.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package salc_pkg;

  // Command codes carried by each input transaction
  typedef enum logic [1:0] {
    CMD_PROBE      = 2'd0,
    CMD_MARK_DIRTY = 2'd1,
    CMD_FILL       = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_t;

  localparam int unsigned LINE_ADDR_W = 48;

  typedef struct packed {
    cmd_t                   cmd;
    logic [LINE_ADDR_W-1:0] line_address;
    logic                   dirty_flag;
  } in_item_t;

  typedef struct packed {
    logic                   hit;
    logic                   victim_valid;
    logic [LINE_ADDR_W-1:0] victim_address;
    logic                   victim_dirty;
  } out_item_t;

  // Front end: take a transaction, work out its set, hand it to the queue
  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_DIV  = 2'd1,
    F_PUSH = 2'd2
  } front_state_t;

  // Back end: clear the valid, dirty and recency rows after reset, then read-modify-write per item
  typedef enum logic [1:0] {
    B_CLEAR = 2'd0,
    B_IDLE  = 2'd1,
    B_EXEC  = 2'd2
  } back_state_t;

endpackage
`default_nettype wire

>>> rtl/core/salc_front.sv
// Front end: accepts transactions and derives the set index (line address mod SETS).
// Depends on salc_pkg; feeds salc_fifo.
`timescale 1ns / 1ps
`default_nettype none
module salc_front #(
  parameter int SETS      = 1024,
  parameter int ADDR_BITS = 48
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  output logic                     busy,
  input  salc_pkg::in_item_t       in_item,
  input  wire                      back_clearing,
  input  wire                      q_full,
  output logic                     q_push,
  output logic [((SETS > 1) ? $clog2(SETS) : 1) + $bits(salc_pkg::in_item_t)-1:0] q_data
);
  import salc_pkg::*;

  localparam int SI   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int KW   = (ADDR_BITS < LINE_ADDR_W) ? ADDR_BITS : LINE_ADDR_W;
  localparam int NCH  = (KW + 7) / 8;
  localparam int CIW  = $clog2(NCH);
  localparam int TB   = NCH * 8;
  localparam bit POW2 = ((SETS & (SETS - 1)) == 0);

  typedef logic [TB-1:0][SI-1:0] pow_tab_t;

  // Weight of each address bit modulo SETS, worked out at elaboration
  function automatic pow_tab_t pow_table();
    pow_tab_t t;
    int       p;
    p = 1 % SETS;
    for (int j = 0; j < TB; j++) begin
      t[j] = SI'(p);
      p    = (p * 2) % SETS;
    end
    return t;
  endfunction

  localparam pow_tab_t POW_MOD = pow_table();

  // Add two residues and bring the sum back below SETS
  function automatic logic [SI-1:0] mod_add(logic [SI-1:0] a, logic [SI-1:0] b);
    logic [SI:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (SI+1)'(SETS)) s = s - (SI+1)'(SETS);
    return SI'(s);
  endfunction

  front_state_t   state_r, state_nxt;
  in_item_t       item_r;
  logic [TB-1:0]  div_sh_r;
  logic [SI-1:0]  rem_r, rem_nxt;
  logic [CIW-1:0] chunk_r;
  logic [SI-1:0]  term [8];
  logic [SI-1:0]  sum1 [4];
  logic [SI-1:0]  sum2 [2];
  logic [SI-1:0]  set_idx;
  logic           accept;

  assign accept = start && !busy;

  // Fold one address byte per cycle: add the weights of its set bits, modulo SETS
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      term[b] = div_sh_r[b] ? POW_MOD[{chunk_r, 3'(b)}] : '0;
    end
    for (int b = 0; b < 4; b++) sum1[b] = mod_add(term[2*b], term[2*b+1]);
    for (int b = 0; b < 2; b++) sum2[b] = mod_add(sum1[2*b], sum1[2*b+1]);
    rem_nxt = mod_add(rem_r, mod_add(sum2[0], sum2[1]));
  end

  assign set_idx = POW2 ? (SI'(item_r.line_address) & SI'(SETS - 1)) : rem_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (POW2) state_nxt = F_PUSH;
          else      state_nxt = F_DIV;
        end
      end
      F_DIV:  if (chunk_r == CIW'(NCH - 1)) state_nxt = F_PUSH;
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy   = (state_r != F_IDLE) || back_clearing;
    q_push = (state_r == F_PUSH) && !q_full;
    q_data = {set_idx, item_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the transaction and advance the residue fold
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r   <= in_item;
      div_sh_r <= TB'(in_item.line_address[KW-1:0]);
      rem_r    <= '0;
      chunk_r  <= '0;
    end else if (state_r == F_DIV) begin
      div_sh_r <= div_sh_r >> 8;
      rem_r    <= rem_nxt;
      chunk_r  <= chunk_r + CIW'(1);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/salc_fifo.sv
// Two-entry queue between front and back end of the cache tag store.
// Depends on salc_pkg only for house consistency; generic width.
`timescale 1ns / 1ps
`default_nettype none
module salc_fifo #(
  parameter int W = 8
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          push,
  input  wire  [W-1:0] push_data,
  output logic         full,
  input  wire          pop,
  output logic [W-1:0] head,
  output logic         empty
);
  import salc_pkg::*;

  logic [W-1:0] ent_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rp_r];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_data;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/salc_back.sv
// Back end: tag, valid, dirty and recency rows per set, with LRU update and eviction.
// Depends on salc_pkg; pops from salc_fifo.
`timescale 1ns / 1ps
`default_nettype none
module salc_back #(
  parameter int SETS      = 1024,
  parameter int WAYS      = 8,
  parameter int ADDR_BITS = 48
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_empty,
  input  wire  [((SETS > 1) ? $clog2(SETS) : 1) + $bits(salc_pkg::in_item_t)-1:0] q_head,
  output logic                q_pop,
  output logic                clearing,
  output logic                out_valid,
  output salc_pkg::out_item_t out_item
);
  import salc_pkg::*;

  localparam int SI = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int RW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int KW = (ADDR_BITS < LINE_ADDR_W) ? ADDR_BITS : LINE_ADDR_W;

  typedef struct packed {
    logic [SI-1:0] set_idx;
    in_item_t      item;
  } entry_t;

  // Row stores, one row per set
  logic [WAYS-1:0]         vld_mem  [SETS];
  logic [WAYS-1:0]         dty_mem  [SETS];
  logic [WAYS-1:0][RW-1:0] rank_mem [SETS];
  logic [WAYS-1:0][KW-1:0] tag_mem  [SETS];

  logic [WAYS-1:0]         vld_rd_r, dty_rd_r;
  logic [WAYS-1:0][RW-1:0] rank_rd_r;
  logic [WAYS-1:0][KW-1:0] tag_rd_r;

  back_state_t state_r, state_nxt;
  logic [SI-1:0] clr_cnt_r;
  entry_t        cur_r, head_e;
  out_item_t     out_item_r, res;
  logic          out_valid_r;

  logic                    row_we, tag_we;
  logic [SI-1:0]           waddr, raddr;
  logic [WAYS-1:0]         vld_new, dty_new, vld_upd, dty_upd;
  logic [WAYS-1:0][RW-1:0] rank_new, rank_upd, rank_id;
  logic [WAYS-1:0][KW-1:0] tag_upd;

  logic [KW-1:0]   addr_k;
  logic [WAYS-1:0] hit_vec, inv_vec, lru_vec;
  logic [RW-1:0]   hit_idx, inv_idx, lru_idx, fill_idx, tgt_idx, old_rank;
  logic            hit_any, inv_any, is_fill, is_probe, is_mark, do_recent;

  assign head_e = entry_t'(q_head);
  assign addr_k = KW'(cur_r.item.line_address);
  assign is_probe = (cur_r.item.cmd == CMD_PROBE);
  assign is_mark  = (cur_r.item.cmd == CMD_MARK_DIRTY);
  assign is_fill  = (cur_r.item.cmd == CMD_FILL);

  // Compare tags and pick hit, lowest invalid and least recent ways
  always_comb begin
    hit_idx = '0;
    inv_idx = '0;
    lru_idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = vld_rd_r[w] && (tag_rd_r[w] == addr_k);
      inv_vec[w] = !vld_rd_r[w];
      lru_vec[w] = (rank_rd_r[w] == '0);
      rank_id[w] = RW'(w);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_idx = RW'(w);
      if (inv_vec[w]) inv_idx = RW'(w);
      if (lru_vec[w]) lru_idx = RW'(w);
    end
    hit_any  = |hit_vec;
    inv_any  = |inv_vec;
    fill_idx = inv_any ? inv_idx : lru_idx;
    tgt_idx  = is_fill ? fill_idx : hit_idx;
    do_recent = (is_probe && hit_any) || (is_fill && !hit_any);
  end

  // Build the updated row and the result
  always_comb begin
    vld_upd  = vld_rd_r;
    dty_upd  = dty_rd_r;
    rank_upd = rank_rd_r;
    tag_upd  = tag_rd_r;
    old_rank = rank_rd_r[tgt_idx];
    res      = '0;
    if (do_recent) begin
      for (int w = 0; w < WAYS; w++) begin
        if (rank_rd_r[w] > old_rank) rank_upd[w] = rank_rd_r[w] - RW'(1);
      end
      rank_upd[tgt_idx] = RW'(WAYS - 1);
    end
    if ((is_probe || is_mark) && hit_any) begin
      res.hit = 1'b1;
      if (is_mark || cur_r.item.dirty_flag) dty_upd[hit_idx] = 1'b1;
    end
    if (is_fill && !hit_any) begin
      if (!inv_any) begin
        res.victim_valid   = 1'b1;
        res.victim_address = LINE_ADDR_W'(tag_rd_r[fill_idx]);
        res.victim_dirty   = dty_rd_r[fill_idx];
      end
      vld_upd[fill_idx] = 1'b1;
      dty_upd[fill_idx] = cur_r.item.dirty_flag;
      tag_upd[fill_idx] = addr_k;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_CLEAR: if (clr_cnt_r == SI'(SETS - 1)) state_nxt = B_IDLE;
      B_IDLE:  if (!q_empty) state_nxt = B_EXEC;
      B_EXEC:  state_nxt = B_IDLE;
      default: state_nxt = B_CLEAR;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    q_pop    = 1'b0;
    row_we   = 1'b0;
    tag_we   = 1'b0;
    clearing = 1'b0;
    waddr    = cur_r.set_idx;
    raddr    = head_e.set_idx;
    vld_new  = vld_upd;
    dty_new  = dty_upd;
    rank_new = rank_upd;
    case (state_r)
      B_CLEAR: begin
        clearing = 1'b1;
        row_we   = 1'b1;
        waddr    = clr_cnt_r;
        vld_new  = '0;
        dty_new  = '0;
        rank_new = rank_id;
      end
      B_IDLE:  q_pop = !q_empty;
      B_EXEC: begin
        row_we = 1'b1;
        tag_we = 1'b1;
      end
      default: clearing = 1'b1;
    endcase
  end

  // Row memories: one write port, registered read
  always_ff @(posedge clk) begin
    if (row_we) begin
      vld_mem[waddr]  <= vld_new;
      dty_mem[waddr]  <= dty_new;
      rank_mem[waddr] <= rank_new;
    end
    if (tag_we) tag_mem[waddr] <= tag_upd;
    vld_rd_r  <= vld_mem[raddr];
    dty_rd_r  <= dty_mem[raddr];
    rank_rd_r <= rank_mem[raddr];
    tag_rd_r  <= tag_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == B_EXEC);
      if (state_r == B_CLEAR) clr_cnt_r <= clr_cnt_r + SI'(1);
    end
  end

  // Hold the popped transaction and the result
  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= head_e;
    if (state_r == B_EXEC) out_item_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

>>> rtl/core/set_assoc_lru_cache_tags.sv
// Top level of the set-associative LRU write-back cache tag store.
// Depends on salc_pkg, salc_front, salc_fifo and salc_back.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Input: drive in_item and raise start; the transaction is taken on a rising
//   edge where start is high and busy is low. Commands: probe, mark dirty, fill.
//   Output: every transaction yields one result, shown on out_item for one cycle
//   with out_valid high. The receiver cannot hold results off.
//   Path: with SETS a power of two, a transaction passes the front register, the
//   queue, the row read and the update before out_valid rises. Otherwise the set
//   index is first folded one address byte per cycle in the front end.
//   Flow: the front end takes no new transaction until the last is in the queue;
//   the back end finishes one read-modify-write of a set row before it pops the
//   next; a two-entry queue decouples the two.
//   Reset: after rst_n the back end clears one set row per cycle, all SETS rows
//   in turn, holding busy high meanwhile.
//   Lines are stored by full (masked) line address, so an evicted address is
//   returned without rebuilding it from tag and set.
module set_assoc_lru_cache_tags #(
  parameter int SETS      = 1024,
  parameter int WAYS      = 8,
  parameter int ADDR_BITS = 48
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  salc_pkg::in_item_t  in_item,
  output logic                out_valid,
  output salc_pkg::out_item_t out_item
);
  import salc_pkg::*;

  localparam int SI = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int QW = SI + $bits(in_item_t);

  logic          q_push, q_pop, q_full, q_empty, clearing;
  logic [QW-1:0] q_data, q_head;

  salc_front #(.SETS(SETS), .ADDR_BITS(ADDR_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .back_clearing(clearing), .q_full(q_full), .q_push(q_push), .q_data(q_data)
  );

  salc_fifo #(.W(QW)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_data), .full(q_full),
    .pop(q_pop), .head(q_head), .empty(q_empty)
  );

  salc_back #(.SETS(SETS), .WAYS(WAYS), .ADDR_BITS(ADDR_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
    .clearing(clearing), .out_valid(out_valid), .out_item(out_item)
  );

endmodule
`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the set-associative LRU cache tag store.
// Depends on salc_pkg and set_assoc_lru_cache_tags; needs no other files.
`timescale 1ns / 1ps
module tb;
  import salc_pkg::*;

  localparam int SETS      = 1024;
  localparam int WAYS      = 8;
  localparam int ADDR_BITS = 48;
  localparam int TAG_W     = ADDR_BITS - 10;
  localparam int N_RANDOM  = 1530;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  set_assoc_lru_cache_tags #(.SETS(SETS), .WAYS(WAYS), .ADDR_BITS(ADDR_BITS)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the tag store
  logic             sh_valid [SETS][WAYS];
  logic             sh_dirty [SETS][WAYS];
  logic [TAG_W-1:0] sh_tag   [SETS][WAYS];
  logic [2:0]       sh_rank  [SETS][WAYS];

  out_item_t pending_results[$];
  int        n_errors = 0;

  // Tags used by the random part: a small pool shared by a few hot sets to provoke hits
  localparam int HOT_SETS = 4;
  logic [9:0]       hot_set [HOT_SETS];
  logic [TAG_W-1:0] tag_pool[12];

  function automatic void promote_way(int s, int w);
    logic [2:0] old_rank;
    old_rank = sh_rank[s][w];
    for (int i = 0; i < WAYS; i++)
      if (sh_rank[s][i] > old_rank) sh_rank[s][i]--;
    sh_rank[s][w] = 3'(WAYS - 1);
  endfunction

  function automatic int lookup_way(int s, logic [TAG_W-1:0] t);
    for (int i = 0; i < WAYS; i++)
      if (sh_valid[s][i] && sh_tag[s][i] == t) return i;
    return WAYS;
  endfunction

  // Work out the result of one transaction and advance the shadow store
  function automatic out_item_t predict_access(in_item_t it);
    out_item_t        r;
    int               s, w;
    logic [TAG_W-1:0] t;
    r = '0;
    s = int'(it.line_address[9:0]);
    t = it.line_address[ADDR_BITS-1:10];
    w = lookup_way(s, t);
    case (it.cmd)
      CMD_PROBE: begin
        if (w < WAYS) begin
          r.hit = 1'b1;
          promote_way(s, w);
          if (it.dirty_flag) sh_dirty[s][w] = 1'b1;
        end
      end
      CMD_MARK_DIRTY: begin
        if (w < WAYS) begin
          r.hit = 1'b1;
          sh_dirty[s][w] = 1'b1;
        end
      end
      CMD_FILL: begin
        if (w == WAYS) begin
          for (int i = WAYS - 1; i >= 0; i--)
            if (!sh_valid[s][i]) w = i;
          if (w == WAYS) begin
            for (int i = WAYS - 1; i >= 0; i--)
              if (sh_rank[s][i] == 3'd0) w = i;
            r.victim_valid   = 1'b1;
            r.victim_address = {sh_tag[s][w], 10'(s)};
            r.victim_dirty   = sh_dirty[s][w];
          end
          sh_valid[s][w] = 1'b1;
          sh_dirty[s][w] = it.dirty_flag;
          sh_tag[s][w]   = t;
          promote_way(s, w);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Drive one transaction, holding start until it is taken
  task automatic send_access(in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_access(it));
  endtask

  // Drop start for a random gap, mostly short, sometimes long
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
      : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Compare every result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", out_item);
        n_errors++;
      end else begin
        out_item_t want;
        want = pending_results.pop_front();
        if (out_item.hit !== want.hit) begin
          $error("hit: expected %0d actual %0d", want.hit, out_item.hit);
          n_errors++;
        end
        if (out_item.victim_valid !== want.victim_valid) begin
          $error("victim_valid: expected %0d actual %0d",
                 want.victim_valid, out_item.victim_valid);
          n_errors++;
        end
        if (out_item.victim_address !== want.victim_address) begin
          $error("victim_address: expected %h actual %h",
                 want.victim_address, out_item.victim_address);
          n_errors++;
        end
        if (out_item.victim_dirty !== want.victim_dirty) begin
          $error("victim_dirty: expected %0d actual %0d",
                 want.victim_dirty, out_item.victim_dirty);
          n_errors++;
        end
      end
    end
  end

  // Directed rows: a typed-in result is checked on top of the prediction
  typedef struct {
    in_item_t  it;
    logic      has_typed;
    out_item_t typed;
  } dir_row_t;

  localparam logic [47:0] A_MAX = 48'hFFFF_FFFF_FFFF;

  function automatic dir_row_t mk(cmd_t c, logic [47:0] a, logic d,
                                  logic ht, out_item_t r);
    dir_row_t x;
    x.it.cmd = c; x.it.line_address = a; x.it.dirty_flag = d;
    x.has_typed = ht; x.typed = r;
    return x;
  endfunction

  initial begin
    dir_row_t   rows[$];
    in_item_t   it;
    out_item_t  none;
    out_item_t  got;
    logic [9:0] s;

    for (int i = 0; i < SETS; i++)
      for (int j = 0; j < WAYS; j++) begin
        sh_valid[i][j] = 1'b0; sh_dirty[i][j] = 1'b0;
        sh_tag[i][j] = '0; sh_rank[i][j] = 3'(j);
      end
    none = '0;

    // After reset everything misses until filled; extremes of the address
    rows.push_back(mk(CMD_PROBE, 48'h0, 1'b1, 1'b1, none));
    rows.push_back(mk(CMD_MARK_DIRTY, A_MAX, 1'b0, 1'b1, none));
    rows.push_back(mk(CMD_NONE, A_MAX, 1'b1, 1'b1, none));
    rows.push_back(mk(CMD_FILL, A_MAX, 1'b1, 1'b1, none));
    rows.push_back(mk(CMD_FILL, A_MAX, 1'b0, 1'b1, none)); // already present
    got = '0; got.hit = 1'b1;
    rows.push_back(mk(CMD_PROBE, A_MAX, 1'b0, 1'b1, got));
    rows.push_back(mk(CMD_MARK_DIRTY, A_MAX, 1'b0, 1'b1, got));
    rows.push_back(mk(CMD_FILL, 48'h0, 1'b0, 1'b1, none));
    rows.push_back(mk(CMD_NONE, 48'h0, 1'b0, 1'b1, none));
    // Fill set 0 past its ways: evictions, clean and dirty, touched LRU order
    for (int k = 1; k <= 9; k++)
      rows.push_back(mk(CMD_FILL, {38'(k * 7919), 10'd0}, 1'(k & 1), 1'b0, none));
    rows.push_back(mk(CMD_PROBE, {38'(2 * 7919), 10'd0}, 1'b1, 1'b0, none));
    rows.push_back(mk(CMD_FILL, {38'h3F_FFFF_FFFF, 10'd0}, 1'b0, 1'b0, none));
    rows.push_back(mk(CMD_FILL, {38'h2A_AAAA_AAAA, 10'd0}, 1'b1, 1'b0, none));
    rows.push_back(mk(CMD_FILL, {38'h15_5555_5555, 10'd0}, 1'b0, 1'b0, none));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].has_typed) begin
        send_access(rows[i].it);
        got = pending_results[$];
        if (got !== rows[i].typed) begin
          $error("row %0d: expected %h predicted %h", i, rows[i].typed, got);
          n_errors++;
        end
      end else begin
        send_access(rows[i].it);
      end
      if ($urandom_range(0, 3) == 0) idle_gap();
    end
    // Let every expected result arrive before going on
    wait_drain();

    for (int i = 0; i < HOT_SETS; i++) hot_set[i] = 10'($urandom);
    for (int i = 0; i < 12; i++) tag_pool[i] = TAG_W'({$urandom, $urandom});

    for (int n = 0; n < N_RANDOM; n++) begin
      it.cmd = cmd_t'($urandom_range(0, 9) < 4 ? CMD_FILL
             : ($urandom_range(0, 9) < 7 ? CMD_PROBE
             : ($urandom_range(0, 9) < 8 ? CMD_MARK_DIRTY : CMD_NONE)));
      it.dirty_flag = 1'($urandom);
      if ($urandom_range(0, 9) < 8) begin
        s = hot_set[$urandom_range(0, HOT_SETS - 1)];
        it.line_address = {tag_pool[$urandom_range(0, 11)], s};
      end else begin
        it.line_address = 48'({$urandom, $urandom});
      end
      send_access(it);
      if (n % 400 == 399) wait_drain();
      else if ($urandom_range(0, 99) >= 30) idle_gap();
    end

    wait_drain();
    repeat (20) @(posedge clk);
    if (n_errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule
